FILE: rtl/pmkw_pkg.sv
// ----------------------------------------------------------------------------
// pmkw_pkg
// Shared widths, kernel codes and coefficient tables for the particle-mesh
// kernel weight unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pmkw_pkg;

    // Fixed-point layout
    localparam int FRAC        = 24;   // fraction bits of the internal format
    localparam int OFFSET_W    = 32;   // offset component, signed Q16.16
    localparam int SPACE_W     = 31;   // grid spacing, unsigned Q15.16
    localparam int NUM_AXES    = 2;    // offset components carried on the bus
    localparam int DIM_DEFAULT = 2;

    // Per-axis evaluation
    localparam int U_W      = 26;      // scaled distance, below 4.0 in Q.24
    localparam int COEF_W   = 10;      // largest coefficient magnitude is 274
    localparam int NUM_COEF = 6;
    localparam int ACC_W    = 36;      // Horner accumulator, signed Q.24
    localparam int ABS_W    = 32;
    localparam int SCL_W    = 2 * ABS_W;
    localparam int MAG_W    = 26;      // per-axis magnitude, Q.24

    // Product and spacing divisions
    localparam int PROD_W  = 28;
    localparam int QUOT_W  = 41;       // holds the cap value 2^40
    localparam int SHIFT_Q = 16;
    localparam int OUT_SHIFT = FRAC - 16;

    localparam logic [U_W-1:0] U_ONE   = U_W'(64'd1 << FRAC);
    localparam logic [U_W-1:0] U_TWO   = U_W'(64'd2 << FRAC);
    localparam logic [U_W-1:0] U_THREE = U_W'(64'd3 << FRAC);

    localparam logic [QUOT_W-1:0] MAG_CAP = QUOT_W'(64'd1 << 40);

    // Reciprocals for the kernel denominators (exact for 32-bit dividends)
    localparam logic [ABS_W-1:0] RECIP3  = 32'hAAAA_AAAB;
    localparam int               SH3     = 33;
    localparam logic [ABS_W-1:0] RECIP15 = 32'h8888_8889;
    localparam int               SH15    = 35;

    // Kernel codes
    localparam logic [1:0] KERN_HAT   = 2'd0;
    localparam logic [1:0] KERN_M4P   = 2'd1;
    localparam logic [1:0] KERN_LAG4  = 2'd2;
    localparam logic [1:0] KERN_QUIN6 = 2'd3;

    localparam logic [SPACE_W-1:0] SPACING_RESET = SPACE_W'(32'h0001_0000);

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t [NUM_COEF-1:0] coef_set_t;   // index d is the u^d term

    // Number of polynomial pieces of each kernel
    function automatic logic [1:0] piece_count(input logic [1:0] kern);
        logic [1:0] n;
        case (kern)
            KERN_HAT:   n = 2'd1;
            KERN_M4P:   n = 2'd2;
            KERN_LAG4:  n = 2'd2;
            KERN_QUIN6: n = 2'd3;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    // Integer coefficients of one piece, times the kernel's denominator
    function automatic coef_set_t coef_lookup(input logic [1:0] kern,
                                              input logic [1:0] piece);
        coef_set_t c;
        c = '0;
        case ({kern, piece})
            {KERN_HAT, 2'd0}:
                c = {COEF_W'(0), COEF_W'(0), COEF_W'(0), COEF_W'(0),
                     COEF_W'(-1), COEF_W'(1)};
            {KERN_M4P, 2'd0}:
                c = {COEF_W'(0), COEF_W'(0), COEF_W'(3), COEF_W'(-5),
                     COEF_W'(0), COEF_W'(2)};
            {KERN_M4P, 2'd1}:
                c = {COEF_W'(0), COEF_W'(0), COEF_W'(-1), COEF_W'(5),
                     COEF_W'(-8), COEF_W'(4)};
            {KERN_LAG4, 2'd0}:
                c = {COEF_W'(0), COEF_W'(0), COEF_W'(3), COEF_W'(-6),
                     COEF_W'(-3), COEF_W'(6)};
            {KERN_LAG4, 2'd1}:
                c = {COEF_W'(0), COEF_W'(0), COEF_W'(-1), COEF_W'(6),
                     COEF_W'(-11), COEF_W'(6)};
            {KERN_QUIN6, 2'd0}:
                c = {COEF_W'(-10), COEF_W'(30), COEF_W'(50), COEF_W'(-150),
                     COEF_W'(-40), COEF_W'(120)};
            {KERN_QUIN6, 2'd1}:
                c = {COEF_W'(5), COEF_W'(-45), COEF_W'(125), COEF_W'(-75),
                     COEF_W'(-130), COEF_W'(120)};
            {KERN_QUIN6, 2'd2}:
                c = {COEF_W'(-1), COEF_W'(15), COEF_W'(-85), COEF_W'(225),
                     COEF_W'(-274), COEF_W'(120)};
            default:
                c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/particle_mesh_kernel_weight_unit.sv
// ----------------------------------------------------------------------------
// particle_mesh_kernel_weight_unit
// Tensor-product particle-mesh interpolation weight from a Q16.16 offset
// vector, with selectable 1-D kernel and programmable grid spacing.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         offset vector, one per transaction
//  m_*       out        weight (tdata) and saturation flag (tuser)
//  p*        in/out     APB registers: 0x0 kernel_select, 0x4 grid_spacing
//
//  One offset vector accepted per cycle unless the pipeline holds; stages:
//  27 bit-per-stage divider stages for the distance scaling, 9 for
//  the kernel evaluation, one for the product, 43 per spacing division
//  (42 divider stages and the clamp) and the output register.
//  Reset is synchronous and active low; it clears valid bits and the APB registers.
//  When a result waits with m_tready low the whole pipeline holds; while
//  the output register is empty, the pipeline keeps moving.
//
// ----------------------------------------------------------------------------
`default_nettype none

module particle_mesh_kernel_weight_unit #(
    parameter int DIMENSIONS = pmkw_pkg::DIM_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] offset_x, [63:32] offset_y
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] weight
    output logic [0:0]  m_tuser,    // [0] saturated
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pmkw_pkg::*;

    localparam logic REG_IDX_KERNEL  = 1'b0;
    localparam logic REG_IDX_SPACING = 1'b1;

    localparam int AXIS_DVD_W = OFFSET_W + FRAC;
    localparam int DIV_DVD_W  = QUOT_W + SHIFT_Q;
    localparam int FIN_W      = QUOT_W - OUT_SHIFT;

    localparam logic [FIN_W-1:0] WMAX_POS = FIN_W'(64'h7FFF_FFFF);
    localparam logic [FIN_W-1:0] WMAX_NEG = FIN_W'(64'h8000_0000);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]         kernel_select_reg;
    logic [SPACE_W-1:0] grid_spacing_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_select_reg <= KERN_M4P;
            grid_spacing_reg  <= SPACING_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_IDX_KERNEL:  kernel_select_reg <= pwdata[1:0];
                REG_IDX_SPACING: grid_spacing_reg  <= pwdata[SPACE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IDX_KERNEL:  prdata = 32'(kernel_select_reg);
            REG_IDX_SPACING: prdata = 32'(grid_spacing_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result is held
    // ------------------------------------------------------------------
    logic pipe_en;
    logic out_valid_reg;

    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en;

    // Absolute offsets, scaled by 2^24 for the distance division
    logic [NUM_AXES-1:0][AXIS_DVD_W-1:0] axis_dvd;

    always_comb begin
        for (int l = 0; l < NUM_AXES; l++) begin
            axis_dvd[l] = {(s_tdata[l*OFFSET_W+OFFSET_W-1]
                            ? OFFSET_W'(-s_tdata[l*OFFSET_W +: OFFSET_W])
                            : s_tdata[l*OFFSET_W +: OFFSET_W]),
                           {FRAC{1'b0}}};
        end
    end

    // u = |offset| * 2^24 / h, both axes side by side
    logic                          udiv_valid;
    logic [NUM_AXES-1:0][U_W-1:0]  udiv_quot;
    logic [NUM_AXES-1:0]           udiv_over;
    logic [1:0]                    udiv_kern;

    pmkw_div #(
        .DVD_W  (AXIS_DVD_W),
        .QUOT_W (U_W),
        .SIDE_W (2),
        .LANES  (NUM_AXES)
    ) u_axis_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (pipe_en),
        .in_valid    (s_tvalid),
        .in_dividend (axis_dvd),
        .in_divisor  (grid_spacing_reg),
        .in_side     (kernel_select_reg),
        .out_valid   (udiv_valid),
        .out_quot    (udiv_quot),
        .out_over    (udiv_over),
        .out_side    (udiv_kern)
    );

    // Kernel evaluation per axis
    logic [NUM_AXES-1:0]            ax_valid;
    logic [NUM_AXES-1:0][MAG_W-1:0] ax_mag;
    logic [NUM_AXES-1:0]            ax_neg;

    genvar l;
    generate
        for (l = 0; l < NUM_AXES; l++) begin : g_axis
            pmkw_axis u_axis (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (pipe_en),
                .in_valid  (udiv_valid),
                .in_u      (udiv_quot[l]),
                .in_over   (udiv_over[l]),
                .in_kern   (udiv_kern),
                .out_valid (ax_valid[l]),
                .out_mag   (ax_mag[l]),
                .out_neg   (ax_neg[l])
            );
        end
    endgenerate

    // Tensor product of the axis magnitudes, sign kept apart
    logic [2*MAG_W-1:0] cmb_prod;
    logic               cmb_valid_reg;
    logic [PROD_W-1:0]  cmb_m_reg;
    logic               cmb_neg_reg;

    assign cmb_prod = ax_mag[0] * ax_mag[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmb_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            cmb_valid_reg <= &ax_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (DIMENSIONS == 1) begin
                cmb_m_reg   <= PROD_W'(ax_mag[0]);
                cmb_neg_reg <= ax_neg[0];
            end else begin
                cmb_m_reg   <= PROD_W'(cmb_prod >> FRAC);
                cmb_neg_reg <= ax_neg[0] ^ ax_neg[1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Division by h once per dimension, each capped at 2^40
    // ------------------------------------------------------------------
    wire               chn_valid [DIMENSIONS+1];
    wire [QUOT_W-1:0]  chn_q     [DIMENSIONS+1];
    wire               chn_neg   [DIMENSIONS+1];

    assign chn_valid[0] = cmb_valid_reg;
    assign chn_q[0]     = QUOT_W'(cmb_m_reg);
    assign chn_neg[0]   = cmb_neg_reg;

    genvar d;
    generate
        for (d = 0; d < DIMENSIONS; d++) begin : g_hdiv
            logic                   div_valid;
            logic [0:0][QUOT_W-1:0] div_quot;
            logic [0:0]             div_over;
            logic [0:0]             div_neg;
            logic                   cap_valid_reg;
            logic [QUOT_W-1:0]      cap_q_reg;
            logic                   cap_neg_reg;

            pmkw_div #(
                .DVD_W  (DIV_DVD_W),
                .QUOT_W (QUOT_W),
                .SIDE_W (1),
                .LANES  (1)
            ) u_hdiv (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .en          (pipe_en),
                .in_valid    (chn_valid[d]),
                .in_dividend ({chn_q[d], {SHIFT_Q{1'b0}}}),
                .in_divisor  (grid_spacing_reg),
                .in_side     (chn_neg[d]),
                .out_valid   (div_valid),
                .out_quot    (div_quot),
                .out_over    (div_over),
                .out_side    (div_neg)
            );

            // Clamp the quotient at the cap
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cap_valid_reg <= 1'b0;
                end else if (pipe_en) begin
                    cap_valid_reg <= div_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    cap_q_reg   <= (div_over[0] || (div_quot[0] > MAG_CAP))
                                   ? MAG_CAP : div_quot[0];
                    cap_neg_reg <= div_neg[0];
                end
            end

            assign chn_valid[d+1] = cap_valid_reg;
            assign chn_q[d+1]     = cap_q_reg;
            assign chn_neg[d+1]   = cap_neg_reg;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Back to Q16.16, sign and saturation
    // ------------------------------------------------------------------
    logic [FIN_W-1:0]    fin_q;
    logic [OFFSET_W-1:0] weight_next;
    logic                sat_next;
    logic [OFFSET_W-1:0] weight_reg;
    logic                sat_reg;

    assign fin_q = chn_q[DIMENSIONS][QUOT_W-1:OUT_SHIFT];

    always_comb begin
        sat_next    = 1'b0;
        weight_next = '0;
        if (grid_spacing_reg == '0) begin
            sat_next = 1'b1;
        end else if (chn_neg[DIMENSIONS]) begin
            if (fin_q > WMAX_NEG) begin
                sat_next    = 1'b1;
                weight_next = OFFSET_W'(-WMAX_NEG);
            end else begin
                weight_next = OFFSET_W'(-fin_q);
            end
        end else begin
            if (fin_q > WMAX_POS) begin
                sat_next    = 1'b1;
                weight_next = OFFSET_W'(WMAX_POS);
            end else begin
                weight_next = OFFSET_W'(fin_q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= chn_valid[DIMENSIONS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            weight_reg <= weight_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = weight_reg;
    assign m_tuser[0] = sat_reg;

endmodule

`default_nettype wire

FILE: rtl/pmkw_div.sv
// ----------------------------------------------------------------------------
// pmkw_div
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// upper part must fall below the divisor, otherwise the over flag is raised
// and the quotient is meaningless.
// ----------------------------------------------------------------------------
`default_nettype none

module pmkw_div #(
    parameter int DVD_W  = 56,
    parameter int QUOT_W = 26,
    parameter int SIDE_W = 1,
    parameter int LANES  = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [LANES-1:0][DVD_W-1:0]          in_dividend,
    input  logic [pmkw_pkg::SPACE_W-1:0]         in_divisor,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [LANES-1:0][QUOT_W-1:0]         out_quot,
    output logic [LANES-1:0]                     out_over,
    output logic [SIDE_W-1:0]                    out_side
);
    import pmkw_pkg::*;

    localparam int HEAD_W = DVD_W - QUOT_W;
    localparam int CMP_W  = (HEAD_W > SPACE_W) ? HEAD_W : SPACE_W;
    localparam int NSTG   = QUOT_W + 1;

    logic [NSTG-1:0]                     valid_reg;
    logic [LANES-1:0][SPACE_W-1:0]       rem_reg  [NSTG];
    logic [LANES-1:0][QUOT_W-1:0]        qd_reg   [NSTG];   // dividend in, quotient out
    logic [LANES-1:0]                    over_reg [NSTG];
    logic [SIDE_W-1:0]                   side_reg [NSTG];

    // Valid bits move with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
        end
    end

    genvar s, l;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stage
            wire [LANES-1:0][SPACE_W-1:0] rem_next;
            wire [LANES-1:0][QUOT_W-1:0]  qd_next;
            wire [LANES-1:0]              over_next;
            wire [SIDE_W-1:0]             side_next;

            if (s == 0) begin : g_load
                // Load: upper dividend bits become the first remainder
                for (l = 0; l < LANES; l++) begin : g_lane
                    wire [CMP_W-1:0] head;
                    assign head         = CMP_W'(in_dividend[l][DVD_W-1:QUOT_W]);
                    assign over_next[l] = head >= CMP_W'(in_divisor);
                    assign rem_next[l]  = head[SPACE_W-1:0];
                    assign qd_next[l]   = in_dividend[l][QUOT_W-1:0];
                end
                assign side_next = in_side;
            end else begin : g_step
                // One trial subtraction per lane
                for (l = 0; l < LANES; l++) begin : g_lane
                    wire [SPACE_W:0] trial;
                    wire             ge;
                    assign trial = {rem_reg[s-1][l], qd_reg[s-1][l][QUOT_W-1]};
                    assign ge    = trial >= {1'b0, in_divisor};
                    assign rem_next[l] = ge ? SPACE_W'(trial - {1'b0, in_divisor})
                                            : trial[SPACE_W-1:0];
                    assign qd_next[l]   = {qd_reg[s-1][l][QUOT_W-2:0], ge};
                    assign over_next[l] = over_reg[s-1][l];
                end
                assign side_next = side_reg[s-1];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next;
                    qd_reg[s]   <= qd_next;
                    over_reg[s] <= over_next;
                    side_reg[s] <= side_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTG-1];
    assign out_quot  = qd_reg[NSTG-1];
    assign out_over  = over_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

`default_nettype wire

FILE: rtl/pmkw_axis.sv
// ----------------------------------------------------------------------------
// pmkw_axis
// One-dimensional kernel evaluation: piece selection, Horner's rule over
// five multiply stages, then division by the kernel denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module pmkw_axis (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pmkw_pkg::U_W-1:0]      in_u,
    input  logic                          in_over,
    input  logic [1:0]                    in_kern,
    output logic                          out_valid,
    output logic [pmkw_pkg::MAG_W-1:0]    out_mag,
    output logic                          out_neg
);
    import pmkw_pkg::*;

    localparam int HRN_STG = NUM_COEF;          // select stage plus five steps
    localparam int AX_STG  = HRN_STG + 3;       // abs, product, shift
    localparam int PROD_HW = ACC_W + U_W + 1;

    logic [AX_STG-1:0] vld_reg;

    // Piece selection, lower piece on a boundary
    logic [1:0] piece;
    logic       beyond;
    logic       sel_zero;
    coef_set_t  sel_coef;

    always_comb begin
        beyond = 1'b0;
        piece  = 2'd0;
        if (in_u <= U_ONE) begin
            piece = 2'd0;
        end else if (in_u <= U_TWO) begin
            piece = 2'd1;
        end else if (in_u <= U_THREE) begin
            piece = 2'd2;
        end else begin
            beyond = 1'b1;
        end
        sel_zero = in_over || beyond || (piece >= piece_count(in_kern));
    end

    assign sel_coef = coef_lookup(in_kern, piece);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[AX_STG-2:0], in_valid};
        end
    end

    // Horner pipeline
    logic signed [ACC_W-1:0] hrn_acc_reg  [HRN_STG];
    logic [U_W-1:0]          hrn_u_reg    [HRN_STG];
    coef_set_t               hrn_coef_reg [HRN_STG];
    logic                    hrn_zero_reg [HRN_STG];
    logic [1:0]              hrn_kern_reg [HRN_STG];

    always_ff @(posedge aclk) begin
        if (en) begin
            hrn_acc_reg[0]  <= ACC_W'($signed(sel_coef[NUM_COEF-1])) <<< FRAC;
            hrn_u_reg[0]    <= in_u;
            hrn_coef_reg[0] <= sel_coef;
            hrn_zero_reg[0] <= sel_zero;
            hrn_kern_reg[0] <= in_kern;
        end
    end

    genvar j;
    generate
        for (j = 1; j < HRN_STG; j++) begin : g_hrn
            logic signed [PROD_HW-1:0] prod;
            logic signed [ACC_W-1:0]   acc_next;

            // floor((acc * u) / 2^24) + c * 2^24
            assign prod     = hrn_acc_reg[j-1] * $signed({1'b0, hrn_u_reg[j-1]});
            assign acc_next = ACC_W'(prod >>> FRAC)
                + (ACC_W'($signed(hrn_coef_reg[j-1][NUM_COEF-1-j])) <<< FRAC);

            always_ff @(posedge aclk) begin
                if (en) begin
                    hrn_acc_reg[j]  <= acc_next;
                    hrn_u_reg[j]    <= hrn_u_reg[j-1];
                    hrn_coef_reg[j] <= hrn_coef_reg[j-1];
                    hrn_zero_reg[j] <= hrn_zero_reg[j-1];
                    hrn_kern_reg[j] <= hrn_kern_reg[j-1];
                end
            end
        end
    endgenerate

    // Magnitude and sign of the polynomial value
    logic [ABS_W-1:0] abs_reg;
    logic             abs_neg_reg;
    logic [1:0]       abs_kern_reg;
    logic             acc_negative;
    logic [ACC_W-1:0] acc_abs;

    assign acc_negative = hrn_acc_reg[HRN_STG-1][ACC_W-1];
    assign acc_abs      = acc_negative ? ACC_W'(-hrn_acc_reg[HRN_STG-1])
                                       : ACC_W'(hrn_acc_reg[HRN_STG-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg      <= hrn_zero_reg[HRN_STG-1] ? '0 : acc_abs[ABS_W-1:0];
            abs_neg_reg  <= !hrn_zero_reg[HRN_STG-1] && acc_negative;
            abs_kern_reg <= hrn_kern_reg[HRN_STG-1];
        end
    end

    // Reciprocal multiply for the denominators 6 and 120
    logic [SCL_W-1:0] scl_next;
    logic [SCL_W-1:0] scl_reg;
    logic             scl_neg_reg;
    logic [1:0]       scl_kern_reg;

    always_comb begin
        case (abs_kern_reg)
            KERN_LAG4:  scl_next = SCL_W'(abs_reg >> 1) * SCL_W'(RECIP3);
            KERN_QUIN6: scl_next = SCL_W'(abs_reg >> 3) * SCL_W'(RECIP15);
            default:    scl_next = SCL_W'(abs_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scl_reg      <= scl_next;
            scl_neg_reg  <= abs_neg_reg;
            scl_kern_reg <= abs_kern_reg;
        end
    end

    // Final shift, truncation toward zero
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;

    always_comb begin
        case (scl_kern_reg)
            KERN_HAT:   mag_next = MAG_W'(scl_reg);
            KERN_M4P:   mag_next = MAG_W'(scl_reg >> 1);
            KERN_LAG4:  mag_next = MAG_W'(scl_reg >> SH3);
            KERN_QUIN6: mag_next = MAG_W'(scl_reg >> SH15);
            default:    mag_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            neg_reg <= scl_neg_reg && (mag_next != '0);
        end
    end

    assign out_valid = vld_reg[AX_STG-1];
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

`default_nettype wire
